// ----- src/tdf_pkg.sv -----
// shared types and constants for the trial division factorizer
package tdf_pkg;

  localparam int WIDTH       = 32;
  localparam int MAX_RESULTS = 32;
  localparam int CNT_W       = $clog2(MAX_RESULTS);
  localparam int STEP_W      = $clog2(WIDTH);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_DECIDE
  } tdf_state_t;

  // what goes into the result register
  typedef enum logic [1:0] {
    SEL_ZERO,
    SEL_DIV,
    SEL_REM
  } tdf_sel_t;

  typedef struct packed {
    logic     load;
    logic     div_start;
    logic     emit;
    tdf_sel_t sel;
    logic     take;
    logic     bump;
  } tdf_cmd_t;

  typedef struct packed {
    logic below_two;
    logic div_done;
    logic le;
    logic zero;
    logic out_free;
    logic cap;
  } tdf_sts_t;

endpackage

// ----- src/trial_division_factorizer_unit.sv -----
// top level of the trial division factorizer
//
// takes one 32-bit unsigned number per input beat and returns its prime factors,
// smallest first and with multiplicity, one output beat per factor; out_last marks
// the final factor and out_largest carries the largest factor so far, so the last
// beat gives the smoothness bound. inputs 0 and 1 give one beat with factor 0.
// one number is worked at a time: in_ready is high only while the block is idle.
// each trial divisor costs one pass of a shared restoring divider plus a pass
// through the check and decide states, so the work for a number grows with the
// number of trial divisors plus factors; the divisors run up to the square root
// of the remainder, which bounds a 32-bit prime at about 65536 trials. results
// go through a one-beat output register, so the block keeps dividing while a
// finished factor waits for out_ready and stalls only when it has the next one.
module trial_division_factorizer_unit
  import tdf_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [WIDTH-1:0] in_number,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [WIDTH-1:0] out_factor,
  output logic [WIDTH-1:0] out_largest,
  output logic             out_last
);

  // command and status between controller and datapath
  tdf_cmd_t cmd;
  tdf_sts_t sts;

  tdf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  tdf_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .in_number   (in_number),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_factor  (out_factor),
    .out_largest (out_largest),
    .out_last    (out_last)
  );

endmodule

// ----- src/tdf_div.sv -----
// iterative restoring divider, one quotient bit per cycle
module tdf_div
  import tdf_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [WIDTH-1:0] dividend,
  input  logic [WIDTH-1:0] divisor,
  output logic [WIDTH-1:0] quotient,
  output logic [WIDTH-1:0] remainder,
  output logic             done
);

  logic [WIDTH-1:0]  q_r;
  logic [WIDTH-1:0]  r_r;
  logic [STEP_W-1:0] cnt_r;
  logic              busy_r;
  logic              done_r;

  logic [WIDTH:0]    shifted;
  logic [WIDTH:0]    dvs_ext;
  logic [WIDTH:0]    diff;
  logic              ge;

  assign shifted = {r_r, q_r[WIDTH-1]};
  assign dvs_ext = {1'b0, divisor};
  assign ge      = (shifted >= dvs_ext);
  assign diff    = shifted - dvs_ext;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + STEP_W'(1);
        if (cnt_r == STEP_W'(WIDTH - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r <= dividend;
      r_r <= '0;
    end else if (busy_r) begin
      q_r <= {q_r[WIDTH-2:0], ge};
      r_r <= ge ? diff[WIDTH-1:0] : shifted[WIDTH-1:0];
    end
  end

  assign quotient  = q_r;
  assign remainder = r_r;
  assign done      = done_r;

endmodule

// ----- src/tdf_dp.sv -----
// datapath: remainder, trial divisor, result count, divider and result register
module tdf_dp
  import tdf_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  tdf_cmd_t         cmd,
  output tdf_sts_t         sts,
  input  logic [WIDTH-1:0] in_number,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [WIDTH-1:0] out_factor,
  output logic [WIDTH-1:0] out_largest,
  output logic             out_last
);

  logic [WIDTH-1:0] rem_r;
  logic [WIDTH-1:0] dvs_r;
  logic [CNT_W-1:0] n_r;
  logic             out_valid_r;
  logic [WIDTH-1:0] out_factor_r;
  logic             out_last_r;

  logic [WIDTH-1:0] quo;
  logic [WIDTH-1:0] remd;
  logic             div_done;
  logic [WIDTH-1:0] emit_val;

  tdf_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (cmd.div_start),
    .dividend  (rem_r),
    .divisor   (dvs_r),
    .quotient  (quo),
    .remainder (remd),
    .done      (div_done)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rem_r <= in_number;
      dvs_r <= WIDTH'(2);
      n_r   <= '0;
    end else begin
      if (cmd.take) begin
        rem_r <= quo;
        n_r   <= n_r + CNT_W'(1);
      end
      if (cmd.bump) begin
        dvs_r <= dvs_r + WIDTH'(1);
      end
    end
  end

  always_comb begin
    case (cmd.sel)
      SEL_ZERO: emit_val = '0;
      SEL_DIV:  emit_val = dvs_r;
      SEL_REM:  emit_val = rem_r;
      default:  emit_val = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_factor_r <= emit_val;
      out_last_r   <= (cmd.sel != SEL_DIV);
    end
  end

  assign sts.below_two = (rem_r < WIDTH'(2));
  assign sts.div_done  = div_done;
  assign sts.le        = (dvs_r <= quo);
  assign sts.zero      = (remd == '0);
  assign sts.out_free  = !out_valid_r || out_ready;
  assign sts.cap       = (n_r == CNT_W'(MAX_RESULTS - 1));

  assign out_valid   = out_valid_r;
  assign out_factor  = out_factor_r;
  assign out_largest = out_factor_r;
  assign out_last    = out_last_r;

endmodule

// ----- src/tdf_ctrl.sv -----
// controller state machine for the trial division loop
module tdf_ctrl
  import tdf_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  tdf_sts_t sts,
  output tdf_cmd_t cmd
);

  tdf_state_t state_r;
  tdf_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        if (!sts.below_two) state_nxt = ST_DIV;
        else if (sts.out_free) state_nxt = ST_IDLE;
      end
      ST_DIV: begin
        if (sts.div_done) state_nxt = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (sts.le && !sts.zero) begin
          state_nxt = ST_CHECK;
        end else if (sts.out_free) begin
          state_nxt = (sts.le && !sts.cap) ? ST_CHECK : ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    cmd.sel  = SEL_ZERO;
    in_ready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_CHECK: begin
        if (!sts.below_two) begin
          cmd.div_start = 1'b1;
        end else begin
          cmd.emit = sts.out_free;
        end
      end
      ST_DIV: begin
      end
      ST_DECIDE: begin
        if (sts.le && !sts.zero) begin
          cmd.bump = 1'b1;
        end else if (sts.le && !sts.cap) begin
          cmd.sel  = SEL_DIV;
          cmd.emit = sts.out_free;
          cmd.take = sts.out_free;
        end else begin
          cmd.sel  = SEL_REM;
          cmd.emit = sts.out_free;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ----- src/tdf_checker.sv -----
// port-level checks for the trial division factorizer, bound to the top level
module tdf_checker
  import tdf_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic [WIDTH-1:0] in_number,
  input logic             out_valid,
  input logic             out_ready,
  input logic [WIDTH-1:0] out_factor,
  input logic [WIDTH-1:0] out_largest,
  input logic             out_last
);

  // a waiting input beat holds its number
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_number))
    else $error("input beat changed while stalled");

  // a waiting result beat holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_factor) && $stable(out_last))
    else $error("result beat changed while stalled");

  // factors come in nondecreasing order, so largest tracks the factor
  a_largest: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_largest == out_factor)
    else $error("largest differs from factor");

  // a zero factor only stands alone for inputs below two
  a_zero_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_factor == '0 |-> out_last)
    else $error("zero factor not marked last");

  // one number at a time: busy right after an input beat
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while busy");

endmodule

bind trial_division_factorizer_unit tdf_checker u_tdf_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .in_number   (in_number),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .out_factor  (out_factor),
  .out_largest (out_largest),
  .out_last    (out_last)
);
